// File: src/cdq_pkg.sv
package cdq_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ADDR_W = 5;
   localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;

   localparam logic [2:0] REG_BASE_X = 3'd0;
   localparam logic [2:0] REG_BASE_Y = 3'd1;
   localparam logic [2:0] REG_BASE_Z = 3'd2;
   localparam logic [2:0] REG_AXIS_X = 3'd3;
   localparam logic [2:0] REG_AXIS_Y = 3'd4;
   localparam logic [2:0] REG_AXIS_Z = 3'd5;
   localparam logic [2:0] REG_HEIGHT = 3'd6;
   localparam logic [2:0] REG_RADIUS = 3'd7;

   typedef struct packed {
      logic signed [31:0] base_x;
      logic signed [31:0] base_y;
      logic signed [31:0] base_z;
      logic signed [17:0] axis_x;
      logic signed [17:0] axis_y;
      logic signed [17:0] axis_z;
      logic [30:0]        cyl_height;
      logic [30:0]        cyl_radius;
   } cdq_cfg_type;

   localparam cdq_cfg_type CFG_RESET = '{
      base_x: 32'sd0,
      base_y: 32'sd0,
      base_z: 32'sd0,
      axis_x: 18'sd0,
      axis_y: 18'sd0,
      axis_z: 18'sd65536,
      cyl_height: 31'd65536,
      cyl_radius: 31'd65536
   };

endpackage

// File: src/cdq_isqrt.sv
module cdq_isqrt #(
   parameter int SB_W = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [63:0]     in_radicand,
   input  logic [SB_W-1:0] in_sb,
   output logic            out_valid,
   output logic [31:0]     out_root,
   output logic [SB_W-1:0] out_sb
);
   localparam int STAGES = 32;

   logic [63:0]     x_ff  [STAGES];
   logic [63:0]     r_ff  [STAGES];
   logic            vld_ff[STAGES];
   logic [SB_W-1:0] sb_ff [STAGES];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      localparam logic [64:0] BIT = 65'(1) << (62 - 2 * j);
      logic [63:0]     x_p;
      logic [63:0]     r_p;
      logic            v_p;
      logic [SB_W-1:0] sb_p;
      logic [64:0]     trial;
      logic            take;
      logic [63:0]     x_in;
      logic [63:0]     r_in;

      if (j == 0) begin : g_first
         assign x_p  = in_radicand;
         assign r_p  = '0;
         assign v_p  = in_valid;
         assign sb_p = in_sb;
      end else begin : g_next
         assign x_p  = x_ff[j-1];
         assign r_p  = r_ff[j-1];
         assign v_p  = vld_ff[j-1];
         assign sb_p = sb_ff[j-1];
      end

      assign trial = {1'b0, r_p} + BIT;
      assign take  = {1'b0, x_p} >= trial;
      assign x_in  = take ? 64'({1'b0, x_p} - trial) : x_p;
      assign r_in  = take ? (r_p >> 1) + BIT[63:0] : r_p >> 1;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= v_p;
         end
         x_ff[j]  <= x_in;
         r_ff[j]  <= r_in;
         sb_ff[j] <= sb_p;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_root  = r_ff[STAGES-1][31:0];
   assign out_sb    = sb_ff[STAGES-1];
endmodule

// File: src/cdq_regs.sv
module cdq_regs (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [cdq_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output cdq_pkg::cdq_cfg_type       cfg
);
   import cdq_pkg::*;

   cdq_cfg_type cfg_ff;
   logic [2:0]  idx;
   logic        wr;

   assign idx    = paddr[ADDR_W-1:2];
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (wr) begin
         unique case (idx)
            REG_BASE_X: cfg_ff.base_x <= pwdata;
            REG_BASE_Y: cfg_ff.base_y <= pwdata;
            REG_BASE_Z: cfg_ff.base_z <= pwdata;
            REG_AXIS_X: cfg_ff.axis_x <= pwdata[17:0];
            REG_AXIS_Y: cfg_ff.axis_y <= pwdata[17:0];
            REG_AXIS_Z: cfg_ff.axis_z <= pwdata[17:0];
            REG_HEIGHT: cfg_ff.cyl_height <= pwdata[30:0];
            REG_RADIUS: cfg_ff.cyl_radius <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_BASE_X: prdata = cfg_ff.base_x;
         REG_BASE_Y: prdata = cfg_ff.base_y;
         REG_BASE_Z: prdata = cfg_ff.base_z;
         REG_AXIS_X: prdata = {14'b0, cfg_ff.axis_x};
         REG_AXIS_Y: prdata = {14'b0, cfg_ff.axis_y};
         REG_AXIS_Z: prdata = {14'b0, cfg_ff.axis_z};
         REG_HEIGHT: prdata = {1'b0, cfg_ff.cyl_height};
         REG_RADIUS: prdata = {1'b0, cfg_ff.cyl_radius};
         default:    prdata = '0;
      endcase
   end
endmodule

// File: src/cylinder_distance_query.sv
// Capped cylinder signed distance. Takes one request per clock cycle, every
// cycle, and passes each one through eight geometry stages, a 32-stage
// square root for the radial length, four stages that form the corner
// distance, a second 32-stage square root and an output register. busy
// never rises, and rsp_valid marks each result for one cycle; the receiver
// must take it then. Write the cylinder registers only while no request is
// in flight.
module cylinder_distance_query (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [31:0]         req_point_x,
   input  logic signed [31:0]         req_point_y,
   input  logic signed [31:0]         req_point_z,
   input  logic [30:0]                req_margin,
   output logic                       rsp_valid,
   output logic signed [31:0]         rsp_signed_distance,
   output logic                       rsp_inside_margin,
   output logic                       rsp_inside_strict,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [cdq_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import cdq_pkg::*;

   localparam int F    = FRAC_BITS;
   localparam int H_W  = 53 - F;
   localparam int HN_W = H_W + 18;
   localparam int VS_W = 33 + F;
   localparam int D_W  = ((HN_W > VS_W) ? HN_W : VS_W) + 1;
   localparam int W_W  = D_W - F;
   localparam int SB1_W = 41;
   localparam int SB2_W = 35;

   cdq_cfg_type cfg;

   cdq_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign busy = 1'b0;

   logic signed [31:0] pt[3];
   logic signed [31:0] bs[3];
   logic signed [17:0] ax[3];

   assign pt[0] = req_point_x;
   assign pt[1] = req_point_y;
   assign pt[2] = req_point_z;
   assign bs[0] = cfg.base_x;
   assign bs[1] = cfg.base_y;
   assign bs[2] = cfg.base_z;
   assign ax[0] = cfg.axis_x;
   assign ax[1] = cfg.axis_y;
   assign ax[2] = cfg.axis_z;

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic s5_vld_ff, s6_vld_ff, s7_vld_ff, s8_vld_ff;
   logic s9_vld_ff, s10_vld_ff, s11_vld_ff, s12_vld_ff;
   logic out_vld_ff;
   logic q1_vld, q2_vld;

   logic signed [32:0]      s1_v_ff[3];
   logic [31:0]             s1_rm_ff;
   logic [30:0]             s1_margin_ff;

   logic signed [50:0]      s2_prod_ff[3];
   logic signed [32:0]      s2_v_ff[3];
   logic [30:0]             s2_margin_ff;
   logic [63:0]             s2_rm2_ff;
   logic [61:0]             s2_rad2_ff;

   logic signed [H_W-1:0]   s3_h_ff;
   logic signed [32:0]      s3_v_ff[3];
   logic [30:0]             s3_margin_ff;
   logic [63:0]             s3_rm2_ff;
   logic [61:0]             s3_rad2_ff;

   logic signed [HN_W-1:0]  s4_hn_ff[3];
   logic signed [32:0]      s4_v_ff[3];
   logic                    s4_hm_ff, s4_hs_ff;
   logic signed [H_W:0]     s4_hp_ff;
   logic [63:0]             s4_rm2_ff;
   logic [61:0]             s4_rad2_ff;

   logic signed [W_W-1:0]   s5_w_ff[3];
   logic                    s5_hm_ff, s5_hs_ff;
   logic signed [H_W:0]     s5_hp_ff;
   logic [63:0]             s5_rm2_ff;
   logic [61:0]             s5_rad2_ff;

   logic [31:0]             s6_a_ff[3];
   logic                    s6_far_ff;
   logic                    s6_hm_ff, s6_hs_ff;
   logic signed [H_W:0]     s6_hp_ff;
   logic [63:0]             s6_rm2_ff;
   logic [61:0]             s6_rad2_ff;

   logic [63:0]             s7_sq_ff[3];
   logic                    s7_far_ff;
   logic                    s7_hm_ff, s7_hs_ff;
   logic signed [H_W:0]     s7_hp_ff;
   logic [63:0]             s7_rm2_ff;
   logic [61:0]             s7_rad2_ff;

   logic [63:0]             s8_r2_ff;
   logic                    s8_far_ff;
   logic                    s8_hm_ff, s8_hs_ff;
   logic signed [H_W:0]     s8_hp_ff;
   logic [63:0]             s8_rm2_ff;
   logic [61:0]             s8_rad2_ff;

   logic signed [32:0]      s9_rp_ff;
   logic signed [H_W:0]     s9_hp_ff;
   logic                    s9_m_ff, s9_s_ff, s9_far_ff;

   logic                    s10_use_ff;
   logic [31:0]             s10_alt_ff;
   logic [30:0]             s10_hp_ff, s10_rp_ff;
   logic                    s10_m_ff, s10_s_ff;

   logic [61:0]             s11_hsq_ff, s11_rsq_ff;
   logic                    s11_use_ff;
   logic [31:0]             s11_alt_ff;
   logic                    s11_m_ff, s11_s_ff;

   logic [63:0]             s12_sum_ff;
   logic                    s12_use_ff;
   logic [31:0]             s12_alt_ff;
   logic                    s12_m_ff, s12_s_ff;

   logic signed [31:0]      out_dist_ff;
   logic                    out_m_ff, out_s_ff;

   // stage combinational signals
   logic signed [32:0]      v_in[3];
   logic [31:0]             rm_in;
   logic signed [52:0]      hsum;
   logic signed [52:0]      hround;
   logic signed [H_W-1:0]   h_in;
   logic signed [H_W:0]     hx, hneg, hdiff, hp_in;
   logic signed [H_W:0]     hlo_sum;
   logic [31:0]             hmax_m;
   logic                    hm_in, hs_in;
   logic signed [D_W-1:0]   dif[3];
   logic signed [D_W-1:0]   dround[3];
   logic signed [W_W-1:0]   w_in[3];
   logic [W_W-1:0]          aw[3];
   logic [2:0]              farw;
   logic [65:0]             r2sum;
   logic                    far8;

   logic [SB1_W-1:0]        q1_sb_in, q1_sb;
   logic [31:0]             q1_root;
   logic                    q1_m_in, q1_s_in;

   logic signed [H_W:0]     q1_hp;
   logic                    q1_m, q1_s, q1_far;
   logic signed [32:0]      rp_in;

   logic                    corner, big, use_in;
   logic signed [H_W:0]     mx;
   logic [31:0]             alt_in;

   logic [SB2_W-1:0]        q2_sb_in, q2_sb;
   logic [31:0]             q2_root;
   logic                    q2_use, q2_m, q2_s;
   logic [31:0]             q2_alt;
   logic signed [31:0]      dist_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v_in[i] = 33'(pt[i]) - 33'(bs[i]);
      end
      rm_in = 32'(cfg.cyl_radius) + 32'(req_margin);
   end

   assign hsum   = 53'(s2_prod_ff[0]) + 53'(s2_prod_ff[1]) + 53'(s2_prod_ff[2]);
   assign hround = hsum + 53'(1 << (F - 1));
   assign h_in   = H_W'(hround >>> F);

   assign hx      = (H_W + 1)'(s3_h_ff);
   assign hlo_sum = hx + $signed((H_W + 1)'({1'b0, s3_margin_ff}));
   assign hmax_m  = 32'(cfg.cyl_height) + 32'(s3_margin_ff);
   assign hm_in   = !hlo_sum[H_W] && (hx <= $signed((H_W + 1)'({1'b0, hmax_m})));
   assign hs_in   = !s3_h_ff[H_W-1] && (hx <= $signed((H_W + 1)'({1'b0, cfg.cyl_height})));
   assign hneg    = -hx;
   assign hdiff   = hx - $signed((H_W + 1)'({1'b0, cfg.cyl_height}));
   assign hp_in   = (hdiff > hneg) ? hdiff : hneg;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dif[i]    = D_W'($signed({s4_v_ff[i], F'(0)})) - D_W'(s4_hn_ff[i]);
         dround[i] = dif[i] + D_W'(1 << (F - 1));
         w_in[i]   = W_W'(dround[i] >>> F);
         aw[i]     = s5_w_ff[i][W_W-1] ? W_W'(-s5_w_ff[i]) : W_W'(s5_w_ff[i]);
         farw[i]   = |aw[i][W_W-1:32];
      end
   end

   assign r2sum = 66'(s7_sq_ff[0]) + 66'(s7_sq_ff[1]) + 66'(s7_sq_ff[2]);
   assign far8  = s7_far_ff || (|r2sum[65:64]);

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         s9_vld_ff  <= 1'b0;
         s10_vld_ff <= 1'b0;
         s11_vld_ff <= 1'b0;
         s12_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= start && !busy;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= s5_vld_ff;
         s7_vld_ff  <= s6_vld_ff;
         s8_vld_ff  <= s7_vld_ff;
         s9_vld_ff  <= q1_vld;
         s10_vld_ff <= s9_vld_ff;
         s11_vld_ff <= s10_vld_ff;
         s12_vld_ff <= s11_vld_ff;
         out_vld_ff <= q2_vld;
      end
   end

   // geometry stages
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s1_v_ff[i]    <= v_in[i];
         s2_prod_ff[i] <= 51'(s1_v_ff[i]) * 51'(ax[i]);
         s2_v_ff[i]    <= s1_v_ff[i];
         s3_v_ff[i]    <= s2_v_ff[i];
         s4_hn_ff[i]   <= HN_W'(s3_h_ff) * HN_W'(ax[i]);
         s4_v_ff[i]    <= s3_v_ff[i];
         s5_w_ff[i]    <= w_in[i];
         s6_a_ff[i]    <= aw[i][31:0];
         s7_sq_ff[i]   <= 64'(s6_a_ff[i]) * 64'(s6_a_ff[i]);
      end
      s1_rm_ff     <= rm_in;
      s1_margin_ff <= req_margin;

      s2_margin_ff <= s1_margin_ff;
      s2_rm2_ff    <= 64'(s1_rm_ff) * 64'(s1_rm_ff);
      s2_rad2_ff   <= 62'(cfg.cyl_radius) * 62'(cfg.cyl_radius);

      s3_h_ff      <= h_in;
      s3_margin_ff <= s2_margin_ff;
      s3_rm2_ff    <= s2_rm2_ff;
      s3_rad2_ff   <= s2_rad2_ff;

      s4_hm_ff   <= hm_in;
      s4_hs_ff   <= hs_in;
      s4_hp_ff   <= hp_in;
      s4_rm2_ff  <= s3_rm2_ff;
      s4_rad2_ff <= s3_rad2_ff;

      s5_hm_ff   <= s4_hm_ff;
      s5_hs_ff   <= s4_hs_ff;
      s5_hp_ff   <= s4_hp_ff;
      s5_rm2_ff  <= s4_rm2_ff;
      s5_rad2_ff <= s4_rad2_ff;

      s6_far_ff  <= |farw;
      s6_hm_ff   <= s5_hm_ff;
      s6_hs_ff   <= s5_hs_ff;
      s6_hp_ff   <= s5_hp_ff;
      s6_rm2_ff  <= s5_rm2_ff;
      s6_rad2_ff <= s5_rad2_ff;

      s7_far_ff  <= s6_far_ff;
      s7_hm_ff   <= s6_hm_ff;
      s7_hs_ff   <= s6_hs_ff;
      s7_hp_ff   <= s6_hp_ff;
      s7_rm2_ff  <= s6_rm2_ff;
      s7_rad2_ff <= s6_rad2_ff;

      s8_r2_ff   <= r2sum[63:0];
      s8_far_ff  <= far8;
      s8_hm_ff   <= s7_hm_ff;
      s8_hs_ff   <= s7_hs_ff;
      s8_hp_ff   <= s7_hp_ff;
      s8_rm2_ff  <= s7_rm2_ff;
      s8_rad2_ff <= s7_rad2_ff;
   end

   assign q1_m_in  = !s8_far_ff && s8_hm_ff && (s8_r2_ff <= s8_rm2_ff);
   assign q1_s_in  = !s8_far_ff && s8_hs_ff && (s8_r2_ff <= 64'(s8_rad2_ff));
   assign q1_sb_in = {s8_hp_ff, q1_m_in, q1_s_in, s8_far_ff};

   cdq_isqrt #(.SB_W(SB1_W)) u_sqrt_r (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s8_vld_ff),
      .in_radicand (s8_r2_ff),
      .in_sb       (q1_sb_in),
      .out_valid   (q1_vld),
      .out_root    (q1_root),
      .out_sb      (q1_sb)
   );

   assign q1_hp  = q1_sb[SB1_W-1:3];
   assign q1_m   = q1_sb[2];
   assign q1_s   = q1_sb[1];
   assign q1_far = q1_sb[0];
   assign rp_in  = $signed({1'b0, q1_root}) - $signed({2'b0, cfg.cyl_radius});

   assign corner = (s9_hp_ff > 0) && (s9_rp_ff > 0);
   assign big    = s9_far_ff || (corner && ((s9_hp_ff > (H_W + 1)'(SAT_MAX))
                                            || (s9_rp_ff > 33'(SAT_MAX))));
   assign use_in = corner && !big;
   assign mx     = (s9_hp_ff > (H_W + 1)'(s9_rp_ff)) ? s9_hp_ff : (H_W + 1)'(s9_rp_ff);
   assign alt_in = (big || (mx > (H_W + 1)'(SAT_MAX))) ? SAT_MAX : mx[31:0];

   // corner distance stages
   always_ff @(posedge clock) begin
      s9_rp_ff  <= rp_in;
      s9_hp_ff  <= q1_hp;
      s9_m_ff   <= q1_m;
      s9_s_ff   <= q1_s;
      s9_far_ff <= q1_far;

      s10_use_ff <= use_in;
      s10_alt_ff <= alt_in;
      s10_hp_ff  <= use_in ? s9_hp_ff[30:0] : 31'd0;
      s10_rp_ff  <= use_in ? s9_rp_ff[30:0] : 31'd0;
      s10_m_ff   <= s9_m_ff;
      s10_s_ff   <= s9_s_ff;

      s11_hsq_ff <= 62'(s10_hp_ff) * 62'(s10_hp_ff);
      s11_rsq_ff <= 62'(s10_rp_ff) * 62'(s10_rp_ff);
      s11_use_ff <= s10_use_ff;
      s11_alt_ff <= s10_alt_ff;
      s11_m_ff   <= s10_m_ff;
      s11_s_ff   <= s10_s_ff;

      s12_sum_ff <= 64'(s11_hsq_ff) + 64'(s11_rsq_ff);
      s12_use_ff <= s11_use_ff;
      s12_alt_ff <= s11_alt_ff;
      s12_m_ff   <= s11_m_ff;
      s12_s_ff   <= s11_s_ff;
   end

   assign q2_sb_in = {s12_use_ff, s12_alt_ff, s12_m_ff, s12_s_ff};

   cdq_isqrt #(.SB_W(SB2_W)) u_sqrt_d (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s12_vld_ff),
      .in_radicand (s12_sum_ff),
      .in_sb       (q2_sb_in),
      .out_valid   (q2_vld),
      .out_root    (q2_root),
      .out_sb      (q2_sb)
   );

   assign q2_use  = q2_sb[34];
   assign q2_alt  = q2_sb[33:2];
   assign q2_m    = q2_sb[1];
   assign q2_s    = q2_sb[0];
   assign dist_in = q2_use ? (q2_root[31] ? SAT_MAX : $signed(q2_root)) : $signed(q2_alt);

   always_ff @(posedge clock) begin
      out_dist_ff <= dist_in;
      out_m_ff    <= q2_m;
      out_s_ff    <= q2_s;
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_signed_distance = out_dist_ff;
   assign rsp_inside_margin   = out_m_ff;
   assign rsp_inside_strict   = out_s_ff;
endmodule

// File: src/cdq_checker.sv
module cdq_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic signed [31:0]         req_point_x,
   input logic signed [31:0]         req_point_y,
   input logic signed [31:0]         req_point_z,
   input logic [30:0]                req_margin,
   input logic                       rsp_valid,
   input logic signed [31:0]         rsp_signed_distance,
   input logic                       rsp_inside_margin,
   input logic                       rsp_inside_strict,
   input logic                       psel,
   input logic                       penable,
   input logic                       pwrite,
   input logic [cdq_pkg::ADDR_W-1:0] paddr,
   input logic [31:0]                pwdata,
   input logic [31:0]                prdata,
   input logic                       pready
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");

   a_strict_in_margin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_strict |-> rsp_inside_margin)
      else $error("strict inside without margin inside");

   a_inside_nonpositive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_strict |-> rsp_signed_distance <= 0)
      else $error("inside point with positive distance");
endmodule

bind cylinder_distance_query cdq_checker u_cdq_checker (.*);
